>>> rtl/core/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer controller and datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

   localparam int unsigned COORD_W = 6;
   localparam int unsigned GRID_W  = 7;
   localparam int unsigned ERR_W   = 8;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [GRID_W-1:0]  grid_type;
   typedef logic [ERR_W-1:0]   err_type;

   typedef enum logic {
      LR_IDLE,
      LR_RUN
   } lr_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;  // Capture a request and set up the line.
      logic step;  // Emit the current pixel and advance.
   } lr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_last;  // The current pixel is the final one of the line.
   } lr_stat_type;

endpackage

>>> rtl/core/lr_ctrl.sv
// ----------------------------------------------------------------------------
// lr_ctrl
// Sequencer for the rasterizer: accepts a request, then walks the datapath
// one pixel per cycle into the response register whenever it is free.
// ----------------------------------------------------------------------------
module lr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lr_pkg::lr_cmd_type cmd,
   input  lr_pkg::lr_stat_type stat
);
   import lr_pkg::*;

   lr_state_type state_ff;
   lr_state_type state_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         out_free;

   // The response register can take a new pixel when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LR_IDLE: begin
            if (req_tvalid) begin
               state_in = LR_RUN;
            end
         end
         LR_RUN: begin
            if (out_free && stat.is_last) begin
               state_in = LR_IDLE;
            end
         end
         default: state_in = LR_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         LR_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         LR_RUN: begin
            cmd.step = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/core/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath
// Line setup, Bresenham stepping registers, grid size register and the
// response payload register.
// ----------------------------------------------------------------------------
module lr_datapath #(
   parameter int unsigned GRID_MAX = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lr_pkg::coord_type    start_x,
   input  lr_pkg::coord_type    start_y,
   input  lr_pkg::coord_type    end_x,
   input  lr_pkg::coord_type    end_y,
   input  logic                 csr_we,
   input  lr_pkg::grid_type     csr_wdata,
   input  lr_pkg::lr_cmd_type   cmd,
   output lr_pkg::lr_stat_type  stat,
   output lr_pkg::coord_type    pixel_x,
   output lr_pkg::coord_type    pixel_y,
   output logic                 visible,
   output logic                 last
);
   import lr_pkg::*;

   grid_type  grid_size_ff;

   coord_type major_pos_ff,   major_pos_in;
   coord_type minor_pos_ff,   minor_pos_in;
   coord_type major_end_ff,   major_end_in;
   coord_type major_delta_ff, major_delta_in;
   coord_type minor_delta_ff, minor_delta_in;
   err_type   err_ff,         err_in;
   logic      minor_dec_ff,   minor_dec_in;
   logic      x_major_ff,     x_major_in;

   coord_type pixel_x_ff, pixel_y_ff;
   logic      visible_ff, last_ff;

   // Setup terms.
   coord_type adx, ady;
   coord_type a_maj, a_min, b_maj, b_min;
   coord_type lo_maj, lo_min, hi_maj, hi_min;
   logic      swap;
   logic      sel_x_major;

   // Step terms.
   coord_type cur_x, cur_y;
   logic      cur_last;
   logic      cur_visible;
   err_type   step_err;
   coord_type step_minor;

   always_comb begin
      adx         = (start_x >= end_x) ? (start_x - end_x) : (end_x - start_x);
      ady         = (start_y >= end_y) ? (start_y - end_y) : (end_y - start_y);
      sel_x_major = (adx >= ady);
      a_maj       = sel_x_major ? start_x : start_y;
      a_min       = sel_x_major ? start_y : start_x;
      b_maj       = sel_x_major ? end_x   : end_y;
      b_min       = sel_x_major ? end_y   : end_x;
      swap        = (a_maj > b_maj);
      lo_maj      = swap ? b_maj : a_maj;
      lo_min      = swap ? b_min : a_min;
      hi_maj      = swap ? a_maj : b_maj;
      hi_min      = swap ? a_min : b_min;
   end

   // Current pixel as seen from the stepping registers.
   assign cur_x       = x_major_ff ? major_pos_ff : minor_pos_ff;
   assign cur_y       = x_major_ff ? minor_pos_ff : major_pos_ff;
   assign cur_last    = (major_pos_ff >= major_end_ff);
   assign cur_visible = ({1'b0, cur_x} < grid_size_ff) && ({1'b0, cur_y} < grid_size_ff);

   always_comb begin
      step_minor = minor_pos_ff;
      step_err   = err_ff + {2'b00, minor_delta_ff};
      // A nonnegative error moves the minor coordinate, clamped to the coordinate range.
      if (!err_ff[ERR_W-1]) begin
         step_err = err_ff + {2'b00, minor_delta_ff} - {2'b00, major_delta_ff};
         if (minor_dec_ff) begin
            if (minor_pos_ff != '0) begin
               step_minor = minor_pos_ff - 1'b1;
            end
         end else begin
            if (minor_pos_ff != '1) begin
               step_minor = minor_pos_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      err_in         = err_ff;
      minor_dec_in   = minor_dec_ff;
      x_major_in     = x_major_ff;
      priority if (cmd.load) begin
         major_pos_in   = lo_maj;
         minor_pos_in   = lo_min;
         major_end_in   = hi_maj;
         major_delta_in = hi_maj - lo_maj;
         minor_delta_in = (hi_min >= lo_min) ? (hi_min - lo_min) : (lo_min - hi_min);
         minor_dec_in   = (hi_min < lo_min);
         x_major_in     = sel_x_major;
         err_in         = {2'b00, minor_delta_in} - {2'b00, major_delta_in};
      end else if (cmd.step) begin
         major_pos_in = major_pos_ff + 1'b1;
         minor_pos_in = step_minor;
         err_in       = step_err;
      end else begin
         err_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_W'(GRID_MAX);
      end else if (csr_we) begin
         grid_size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      err_ff         <= err_in;
      minor_dec_ff   <= minor_dec_in;
      x_major_ff     <= x_major_in;
      if (cmd.step) begin
         pixel_x_ff <= cur_x;
         pixel_y_ff <= cur_y;
         visible_ff <= cur_visible;
         last_ff    <= cur_last;
      end
   end

   assign stat.is_last = cur_last;
   assign pixel_x      = pixel_x_ff;
   assign pixel_y      = pixel_y_ff;
   assign visible      = visible_ff;
   assign last         = last_ff;

endmodule

>>> rtl/core/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer: one request with two endpoints yields one
// response per pixel, in ascending order along the major axis.
// ----------------------------------------------------------------------------
// An accepted request is loaded into the stepping registers, and each pixel is
// then registered in the response register: one pixel per cycle while the
// response register is free to take it (rsp_tready back-pressure stalls stepping).
// The next request is taken once the last pixel sits in the response register.
// Reset (synchronous, active high) returns to idle and sets grid_size to GRID_MAX.
module line_rasterizer #(
   parameter int unsigned GRID_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // start_x, start_y, end_x, end_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pixel_x, pixel_y, zero fill
   output logic        rsp_tuser,   // visible
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // grid_size
);
   import lr_pkg::*;

   lr_cmd_type  cmd;
   lr_stat_type stat;
   coord_type   pixel_x;
   coord_type   pixel_y;

   lr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   lr_datapath #(
      .GRID_MAX (GRID_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .start_x   (req_tdata[5:0]),
      .start_y   (req_tdata[11:6]),
      .end_x     (req_tdata[17:12]),
      .end_y     (req_tdata[23:18]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .pixel_x   (pixel_x),
      .pixel_y   (pixel_y),
      .visible   (rsp_tuser),
      .last      (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, pixel_y, pixel_x};

   // An accepted request keeps the block busy for at least its first pixel.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a line was still being traced");

   // Loading a new line and stepping the current one never coincide.
   a_load_step_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and step issued together");

   // Stepping the final pixel returns the controller to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && stat.is_last) |=> req_tready)
      else $error("controller stayed busy after the last pixel");

   // While idle, any pixel still waiting must be the last of its line.
   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      (req_tready && rsp_tvalid) |-> rsp_tlast)
      else $error("idle with a non-final pixel pending");

endmodule
